### rtl/wcac_pkg.sv
// Shared constants, codes and types for the write-back cache add controller.
package wcac_pkg;

  localparam int SETS  = 4096;
  localparam int IDX_W = $clog2(SETS);

  localparam logic [1:0] KIND_ADD   = 2'd0;
  localparam logic [1:0] KIND_LOAD  = 2'd1;
  localparam logic [1:0] KIND_ACK   = 2'd2;
  localparam logic [1:0] KIND_FLUSH = 2'd3;

  localparam logic [2:0] CMD_LOAD       = 3'd0;
  localparam logic [2:0] CMD_STORE      = 3'd1;
  localparam logic [2:0] CMD_ADD_DONE   = 3'd2;
  localparam logic [2:0] CMD_FLUSH_DONE = 3'd3;
  localparam logic [2:0] CMD_IDLE       = 3'd4;

  localparam logic [1:0] ST_EMPTY = 2'd0;
  localparam logic [1:0] ST_CLEAN = 2'd1;
  localparam logic [1:0] ST_DIRTY = 2'd2;

  localparam logic [1:0] PH_A     = 2'd0;
  localparam logic [1:0] PH_B     = 2'd1;
  localparam logic [1:0] PH_D     = 2'd2;
  localparam logic [1:0] PH_FLUSH = 2'd3;

  localparam logic [1:0] WAIT_NONE  = 2'd0;
  localparam logic [1:0] WAIT_LOAD  = 2'd1;
  localparam logic [1:0] WAIT_STORE = 2'd2;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] tag;
    logic [31:0] value;
  } line_t;

  localparam int LINE_W = $bits(line_t);

endpackage

### rtl/wcac_if.sv
// Valid/ready channel interfaces for requests and responses.
interface wcac_req_if;
  logic               valid;
  logic               ready;
  logic [1:0]         kind;
  logic [31:0]        src_a_addr;
  logic [31:0]        src_b_addr;
  logic [31:0]        dest_addr;
  logic signed [31:0] load_value;
  modport source (output valid, kind, src_a_addr, src_b_addr, dest_addr, load_value,
                  input ready);
  modport sink (input valid, kind, src_a_addr, src_b_addr, dest_addr, load_value,
                output ready);
endinterface

interface wcac_rsp_if;
  logic               valid;
  logic               ready;
  logic [2:0]         command;
  logic [31:0]        mem_addr;
  logic signed [31:0] store_data;
  modport source (output valid, command, mem_addr, store_data, input ready);
  modport sink (input valid, command, mem_addr, store_data, output ready);
endinterface

### rtl/wcac_ram.sv
// Generic single-write, single-read RAM with registered read data.
module wcac_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

### rtl/writeback_cache_add_controller.sv
// Top level of the direct-mapped write-back cache add controller.
//
//   channel | dir | beat contents
//   --------+-----+--------------------------------------------------------
//   req_ch  | in  | kind, src_a_addr, src_b_addr, dest_addr, load_value
//   rsp_ch  | out | command, mem_addr, store_data (exactly one per request)
//
// One request beat is handled at a time. Every line lookup is a memory read,
// then an evaluate, so an add takes one to three lookups plus accept and
// result. A flush walks the lines one at a time, each with a read and an
// evaluate. After reset a clearing pass marks every line empty; no request is
// taken until it ends. The response sits in an output register, so a stalled
// response side holds only the next result, not the acceptance of the next
// request.
module writeback_cache_add_controller (
  input logic        clk,
  input logic        rst,
  wcac_req_if.sink   req_ch,
  wcac_rsp_if.source rsp_ch
);
  import wcac_pkg::*;

  typedef enum logic [8:0] {
    S_CLEAR   = 9'b000000001,
    S_IDLE    = 9'b000000010,
    S_LOAD_WR = 9'b000000100,
    S_ACK_WR  = 9'b000001000,
    S_ADV_RD  = 9'b000010000,
    S_ADV_EV  = 9'b000100000,
    S_SCAN_RD = 9'b001000000,
    S_SCAN_EV = 9'b010000000,
    S_EMIT    = 9'b100000000
  } state_t;

  state_t state, state_next;

  // Request context.
  logic [1:0]       phase, phase_next;
  logic [1:0]       waiting, waiting_next;
  logic [31:0]      addr_a, addr_a_next, addr_b, addr_b_next, addr_d, addr_d_next;
  logic [31:0]      opnd_a, opnd_a_next, opnd_b, opnd_b_next;
  logic [31:0]      load_val, load_val_next;
  logic [IDX_W-1:0] fidx, fidx_next;

  // Victim line kept while its write-back is outstanding.
  logic [IDX_W-1:0] vidx, vidx_next;
  logic [31:0]      vtag, vtag_next, vval, vval_next;

  // Pending result and output register.
  logic [2:0]  pend_cmd, pend_cmd_next;
  logic [31:0] pend_addr, pend_addr_next, pend_data, pend_data_next;
  logic        out_valid, out_valid_next;
  logic [2:0]  out_cmd, out_cmd_next;
  logic [31:0] out_addr, out_addr_next, out_data, out_data_next;

  // Line memory.
  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr, mem_raddr;
  line_t            mem_wdata, mem_rdata;
  logic [LINE_W-1:0] mem_rbits;

  wcac_ram #(.WIDTH(LINE_W), .DEPTH(SETS)) u_lines (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rbits)
  );
  assign mem_rdata = line_t'(mem_rbits);

  logic [31:0]      cur_addr;
  logic [IDX_W-1:0] cur_idx;
  logic             hit, req_fire, out_fire, fidx_last;

  always_comb begin
    case (phase)
      PH_A:    cur_addr = addr_a;
      PH_B:    cur_addr = addr_b;
      default: cur_addr = addr_d;
    endcase
  end
  assign cur_idx   = cur_addr[IDX_W-1:0];
  assign hit       = (mem_rdata.status != ST_EMPTY) && (mem_rdata.tag == cur_addr);
  assign fidx_last = (fidx == IDX_W'(SETS - 1));

  assign req_ch.ready      = (state == S_IDLE);
  assign req_fire          = req_ch.valid && req_ch.ready;
  assign out_fire          = out_valid && rsp_ch.ready;
  assign rsp_ch.valid      = out_valid;
  assign rsp_ch.command    = out_cmd;
  assign rsp_ch.mem_addr   = out_addr;
  assign rsp_ch.store_data = $signed(out_data);

  always_comb begin
    state_next     = state;
    phase_next     = phase;
    waiting_next   = waiting;
    addr_a_next    = addr_a;
    addr_b_next    = addr_b;
    addr_d_next    = addr_d;
    opnd_a_next    = opnd_a;
    opnd_b_next    = opnd_b;
    load_val_next  = load_val;
    fidx_next      = fidx;
    vidx_next      = vidx;
    vtag_next      = vtag;
    vval_next      = vval;
    pend_cmd_next  = pend_cmd;
    pend_addr_next = pend_addr;
    pend_data_next = pend_data;
    out_valid_next = out_valid && !out_fire;
    out_cmd_next   = out_cmd;
    out_addr_next  = out_addr;
    out_data_next  = out_data;
    mem_we         = 1'b0;
    mem_waddr      = cur_idx;
    mem_wdata      = '{status: ST_EMPTY, tag: 32'd0, value: 32'd0};
    mem_raddr      = cur_idx;

    case (state)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = fidx;
        if (fidx_last) begin
          fidx_next  = '0;
          state_next = S_IDLE;
        end else begin
          fidx_next = fidx + IDX_W'(1);
        end
      end

      S_IDLE: begin
        if (req_fire) begin
          pend_cmd_next  = CMD_IDLE;
          pend_addr_next = 32'd0;
          pend_data_next = 32'd0;
          state_next     = S_EMIT;
          case (req_ch.kind)
            KIND_ADD: begin
              if (waiting == WAIT_NONE) begin
                addr_a_next = req_ch.src_a_addr;
                addr_b_next = req_ch.src_b_addr;
                addr_d_next = req_ch.dest_addr;
                phase_next  = PH_A;
                state_next  = S_ADV_RD;
              end
            end
            KIND_LOAD: begin
              if (waiting == WAIT_LOAD && (phase == PH_A || phase == PH_B)) begin
                load_val_next = req_ch.load_value;
                state_next    = S_LOAD_WR;
              end
            end
            KIND_ACK: begin
              if (waiting == WAIT_STORE) begin
                waiting_next = WAIT_NONE;
                state_next   = S_ACK_WR;
              end
            end
            default: begin
              if (waiting == WAIT_NONE) begin
                phase_next = PH_FLUSH;
                fidx_next  = '0;
                state_next = S_SCAN_RD;
              end
            end
          endcase
        end
      end

      S_LOAD_WR: begin
        mem_we    = 1'b1;
        mem_wdata = '{status: ST_CLEAN, tag: cur_addr, value: load_val};
        if (phase == PH_A) begin
          opnd_a_next = load_val;
        end else begin
          opnd_b_next = load_val;
        end
        phase_next   = phase + 2'd1;
        waiting_next = WAIT_NONE;
        state_next   = S_ADV_RD;
      end

      S_ACK_WR: begin
        // The written-back victim stays resident as a clean line.
        mem_we    = 1'b1;
        mem_waddr = vidx;
        mem_wdata = '{status: ST_CLEAN, tag: vtag, value: vval};
        if (phase == PH_FLUSH) begin
          if (fidx_last) begin
            fidx_next      = '0;
            phase_next     = PH_A;
            pend_cmd_next  = CMD_FLUSH_DONE;
            pend_addr_next = 32'd0;
            pend_data_next = 32'd0;
            state_next     = S_EMIT;
          end else begin
            fidx_next  = fidx + IDX_W'(1);
            state_next = S_SCAN_RD;
          end
        end else begin
          state_next = S_ADV_RD;
        end
      end

      S_ADV_RD: begin
        state_next = S_ADV_EV;
      end

      S_ADV_EV: begin
        state_next = S_EMIT;
        if (phase != PH_D) begin
          if (hit) begin
            if (phase == PH_A) begin
              opnd_a_next = mem_rdata.value;
            end else begin
              opnd_b_next = mem_rdata.value;
            end
            phase_next = phase + 2'd1;
            state_next = S_ADV_RD;
          end else if (mem_rdata.status == ST_DIRTY) begin
            pend_cmd_next  = CMD_STORE;
            pend_addr_next = mem_rdata.tag;
            pend_data_next = mem_rdata.value;
            vidx_next      = cur_idx;
            vtag_next      = mem_rdata.tag;
            vval_next      = mem_rdata.value;
            waiting_next   = WAIT_STORE;
          end else begin
            pend_cmd_next  = CMD_LOAD;
            pend_addr_next = cur_addr;
            pend_data_next = 32'd0;
            waiting_next   = WAIT_LOAD;
          end
        end else if (mem_rdata.status == ST_DIRTY && mem_rdata.tag != cur_addr) begin
          pend_cmd_next  = CMD_STORE;
          pend_addr_next = mem_rdata.tag;
          pend_data_next = mem_rdata.value;
          vidx_next      = cur_idx;
          vtag_next      = mem_rdata.tag;
          vval_next      = mem_rdata.value;
          waiting_next   = WAIT_STORE;
        end else begin
          mem_we         = 1'b1;
          mem_wdata      = '{status: ST_DIRTY, tag: cur_addr, value: opnd_a + opnd_b};
          pend_cmd_next  = CMD_ADD_DONE;
          pend_addr_next = 32'd0;
          pend_data_next = 32'd0;
          waiting_next   = WAIT_NONE;
          phase_next     = PH_A;
        end
      end

      S_SCAN_RD: begin
        mem_raddr  = fidx;
        state_next = S_SCAN_EV;
      end

      S_SCAN_EV: begin
        if (mem_rdata.status == ST_DIRTY) begin
          pend_cmd_next  = CMD_STORE;
          pend_addr_next = mem_rdata.tag;
          pend_data_next = mem_rdata.value;
          vidx_next      = fidx;
          vtag_next      = mem_rdata.tag;
          vval_next      = mem_rdata.value;
          waiting_next   = WAIT_STORE;
          state_next     = S_EMIT;
        end else if (fidx_last) begin
          fidx_next      = '0;
          phase_next     = PH_A;
          pend_cmd_next  = CMD_FLUSH_DONE;
          pend_addr_next = 32'd0;
          pend_data_next = 32'd0;
          state_next     = S_EMIT;
        end else begin
          fidx_next  = fidx + IDX_W'(1);
          state_next = S_SCAN_RD;
        end
      end

      S_EMIT: begin
        if (!out_valid || rsp_ch.ready) begin
          out_valid_next = 1'b1;
          out_cmd_next   = pend_cmd;
          out_addr_next  = pend_addr;
          out_data_next  = pend_data;
          state_next     = S_IDLE;
        end
      end

      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      phase     <= PH_A;
      waiting   <= WAIT_NONE;
      fidx      <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      phase     <= phase_next;
      waiting   <= waiting_next;
      fidx      <= fidx_next;
      out_valid <= out_valid_next;
    end
    addr_a    <= addr_a_next;
    addr_b    <= addr_b_next;
    addr_d    <= addr_d_next;
    opnd_a    <= opnd_a_next;
    opnd_b    <= opnd_b_next;
    load_val  <= load_val_next;
    vidx      <= vidx_next;
    vtag      <= vtag_next;
    vval      <= vval_next;
    pend_cmd  <= pend_cmd_next;
    pend_addr <= pend_addr_next;
    pend_data <= pend_data_next;
    out_cmd   <= out_cmd_next;
    out_addr  <= out_addr_next;
    out_data  <= out_data_next;
  end
endmodule

### test/writeback_cache_add_controller_tb.sv
// Self-checking testbench for the write-back cache add controller.
module writeback_cache_add_controller_tb;
  import wcac_pkg::*;

  typedef struct packed {
    logic [2:0]  command;
    logic [31:0] mem_addr;
    logic [31:0] store_data;
  } mem_cmd_t;

  // Tracks the cache contents and the controller state, and holds the commands
  // that the controller still owes on its response channel.
  class cache_scoreboard;
    logic [31:0] tag_mem [SETS];
    logic [31:0] value_mem [SETS];
    logic [1:0]  status_mem [SETS];
    logic [1:0]  phase;
    logic [31:0] addr_reg [3];
    logic [31:0] operand [2];
    int          scan_idx;
    logic [1:0]  waiting;
    mem_cmd_t    owed [$];
    int          mismatches;

    function new();
      for (int i = 0; i < SETS; i++) begin
        status_mem[i] = ST_EMPTY;
        tag_mem[i] = '0;
        value_mem[i] = '0;
      end
      phase = PH_A;
      addr_reg = '{default: '0};
      operand = '{default: '0};
      scan_idx = 0;
      waiting = WAIT_NONE;
      mismatches = 0;
    endfunction

    function int unsigned set_of(logic [31:0] addr);
      return addr % SETS;
    endfunction

    function mem_cmd_t cmd(logic [2:0] c, logic [31:0] a, logic [31:0] d);
      mem_cmd_t r;
      r.command = c;
      r.mem_addr = a;
      r.store_data = d;
      return r;
    endfunction

    // Walks the operand lookups until memory is needed or the sum is written.
    function mem_cmd_t walk_operands();
      int unsigned idx;
      while (phase < PH_D) begin
        idx = set_of(addr_reg[phase]);
        if (status_mem[idx] != ST_EMPTY && tag_mem[idx] == addr_reg[phase]) begin
          operand[phase] = value_mem[idx];
          phase++;
        end else if (status_mem[idx] == ST_DIRTY) begin
          waiting = WAIT_STORE;
          return cmd(CMD_STORE, tag_mem[idx], value_mem[idx]);
        end else begin
          waiting = WAIT_LOAD;
          return cmd(CMD_LOAD, addr_reg[phase], '0);
        end
      end
      idx = set_of(addr_reg[2]);
      if (status_mem[idx] == ST_DIRTY && tag_mem[idx] != addr_reg[2]) begin
        waiting = WAIT_STORE;
        return cmd(CMD_STORE, tag_mem[idx], value_mem[idx]);
      end
      value_mem[idx] = operand[0] + operand[1];
      tag_mem[idx] = addr_reg[2];
      status_mem[idx] = ST_DIRTY;
      waiting = WAIT_NONE;
      phase = PH_A;
      return cmd(CMD_ADD_DONE, '0, '0);
    endfunction

    // Resumes the flush from the current line.
    function mem_cmd_t flush_scan();
      while (scan_idx < SETS) begin
        if (status_mem[scan_idx] == ST_DIRTY) begin
          waiting = WAIT_STORE;
          return cmd(CMD_STORE, tag_mem[scan_idx], value_mem[scan_idx]);
        end
        scan_idx++;
      end
      waiting = WAIT_NONE;
      phase = PH_A;
      scan_idx = 0;
      return cmd(CMD_FLUSH_DONE, '0, '0);
    endfunction

    function void note_request(logic [1:0] kind, logic [31:0] a, logic [31:0] b,
                               logic [31:0] d, logic [31:0] lv);
      mem_cmd_t r;
      int unsigned idx;
      r = cmd(CMD_IDLE, '0, '0);
      case (kind)
        KIND_ADD: begin
          if (waiting == WAIT_NONE) begin
            addr_reg[0] = a;
            addr_reg[1] = b;
            addr_reg[2] = d;
            phase = PH_A;
            r = walk_operands();
          end
        end
        KIND_LOAD: begin
          if (waiting == WAIT_LOAD && phase < PH_D) begin
            idx = set_of(addr_reg[phase]);
            tag_mem[idx] = addr_reg[phase];
            value_mem[idx] = lv;
            status_mem[idx] = ST_CLEAN;
            operand[phase] = lv;
            phase++;
            waiting = WAIT_NONE;
            r = walk_operands();
          end
        end
        KIND_ACK: begin
          if (waiting == WAIT_STORE) begin
            waiting = WAIT_NONE;
            if (phase == PH_FLUSH) begin
              if (scan_idx < SETS) begin
                status_mem[scan_idx] = ST_CLEAN;
                scan_idx++;
              end
              r = flush_scan();
            end else begin
              status_mem[set_of(addr_reg[phase])] = ST_CLEAN;
              r = walk_operands();
            end
          end
        end
        default: begin
          if (waiting == WAIT_NONE) begin
            phase = PH_FLUSH;
            scan_idx = 0;
            r = flush_scan();
          end
        end
      endcase
      owed.push_back(r);
    endfunction

    function void check_response(mem_cmd_t got);
      mem_cmd_t exp;
      if (owed.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected response: command %0d addr %h data %h",
                   got.command, got.mem_addr, got.store_data);
        return;
      end
      exp = owed.pop_front();
      if (got.command !== exp.command || got.mem_addr !== exp.mem_addr ||
          got.store_data !== exp.store_data) begin
        mismatches++;
        if (mismatches <= 10)
          $display("response mismatch: expected %0d/%h/%h, got %0d/%h/%h",
                   exp.command, exp.mem_addr, exp.store_data,
                   got.command, got.mem_addr, got.store_data);
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  wcac_req_if req_ch ();
  wcac_rsp_if rsp_ch ();

  writeback_cache_add_controller u_top (
    .clk    (clk),
    .rst    (rst),
    .req_ch (req_ch),
    .rsp_ch (rsp_ch)
  );

  cache_scoreboard sb = new();

  // Set by the request side to turn off random idling on both channels.
  bit quiet_stretch = 0;
  // Cycles the response side must still hold ready low.
  int hold_off = 0;
  int flush_count = 0;

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // This timeout is many times the slowest legal run, including the clearing
  // pass and every flush.
  initial begin
    #40000000;
    $display("writeback_cache_add_controller_tb: FAIL");
    $finish;
  end

  // Response side: checks every beat, stalls at random, and honors hold-offs.
  initial begin
    rsp_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && rsp_ch.valid && rsp_ch.ready)
        sb.check_response({rsp_ch.command, rsp_ch.mem_addr, rsp_ch.store_data});
      if (hold_off > 0) begin
        hold_off--;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= quiet_stretch || ($urandom_range(99) >= 6);
      end
    end
  end

  // Presents one request beat and returns at the edge where it is taken.
  // The next beat, or an idle gap, is set up at that same edge, so valid
  // gets only one assignment per step.
  task automatic send_beat(logic [1:0] kind, logic [31:0] a, logic [31:0] b,
                           logic [31:0] d, logic [31:0] lv);
    if (!quiet_stretch && $urandom_range(99) < 6) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.kind <= kind;
    req_ch.src_a_addr <= a;
    req_ch.src_b_addr <= b;
    req_ch.dest_addr <= d;
    req_ch.load_value <= lv;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    sb.note_request(kind, a, b, d, lv);
  endtask

  // Most addresses come from a few sets and a few tags, so hits, evictions
  // and dirty write-backs happen often; the rest are fully random.
  function automatic logic [31:0] pick_addr();
    logic [19:0] tag;
    logic [11:0] idx;
    if ($urandom_range(7) == 0) return $urandom;
    case ($urandom_range(3))
      0: tag = 20'h0;
      1: tag = 20'h1;
      2: tag = 20'hFFFFF;
      default: tag = 20'($urandom);
    endcase
    case ($urandom_range(5))
      0: idx = 12'd0;
      1: idx = 12'd1;
      2: idx = 12'd2;
      3: idx = 12'd4095;
      4: idx = 12'd2048;
      default: idx = 12'($urandom);
    endcase
    return {tag, idx};
  endfunction

  function automatic logic [31:0] pick_word();
    case ($urandom_range(5))
      0: return 32'h7FFFFFFF;
      1: return 32'h80000000;
      2: return 32'hFFFFFFFF;
      default: return $urandom;
    endcase
  endfunction

  // Answers whatever memory operation the controller is waiting on.
  task automatic serve_memory();
    while (sb.waiting != WAIT_NONE) begin
      if (sb.waiting == WAIT_LOAD) send_beat(KIND_LOAD, '0, '0, '0, pick_word());
      else send_beat(KIND_ACK, $urandom, $urandom, $urandom, $urandom);
    end
  endtask

  // One well-formed step: an answer if memory is pending, else a new add or,
  // rarely, a flush. A tenth of the beats are random noise instead.
  task automatic random_step();
    logic [1:0] kind;
    if ($urandom_range(9) == 0) begin
      kind = 2'($urandom_range(3));
      if (kind == KIND_FLUSH && flush_count >= 8) kind = KIND_ACK;
      if (kind == KIND_FLUSH && sb.waiting == WAIT_NONE) flush_count++;
      send_beat(kind, pick_addr(), pick_addr(), pick_addr(), pick_word());
    end else if (sb.waiting == WAIT_LOAD) begin
      send_beat(KIND_LOAD, $urandom, $urandom, $urandom, pick_word());
    end else if (sb.waiting == WAIT_STORE) begin
      send_beat(KIND_ACK, $urandom, $urandom, $urandom, $urandom);
    end else if (flush_count < 8 && $urandom_range(99) == 0) begin
      flush_count++;
      send_beat(KIND_FLUSH, $urandom, $urandom, $urandom, $urandom);
    end else begin
      send_beat(KIND_ADD, pick_addr(), pick_addr(), pick_addr(), $urandom);
    end
  endtask

  initial begin
    rst = 1'b1;
    req_ch.valid = 1'b0;
    req_ch.kind = KIND_ADD;
    req_ch.src_a_addr = '0;
    req_ch.src_b_addr = '0;
    req_ch.dest_addr = '0;
    req_ch.load_value = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // A flush on an empty cache completes without any write-back; stray data and
    // acknowledges are ignored.
    send_beat(KIND_FLUSH, '0, '0, '0, '0);
    send_beat(KIND_ACK, '0, '0, '0, '0);
    send_beat(KIND_LOAD, '0, '0, '0, 32'h12345678);

    // Extreme addresses and values; an add and a flush that arrive while a
    // load is outstanding are both ignored.
    send_beat(KIND_ADD, 32'h0, 32'hFFFFFFFF, 32'h00001000, '0);
    send_beat(KIND_LOAD, '0, '0, '0, 32'h7FFFFFFF);
    send_beat(KIND_ADD, 32'h5, 32'h6, 32'h7, '0);
    send_beat(KIND_FLUSH, '0, '0, '0, '0);
    send_beat(KIND_LOAD, '0, '0, '0, 32'h80000000);
    serve_memory();

    // All three operands share one set and evict one another.
    send_beat(KIND_ADD, 32'h00000005, 32'h00001005, 32'h00002005, '0);
    serve_memory();
    // The destination line above is dirty and gets written back as a victim.
    send_beat(KIND_ADD, 32'hFFFFF005, 32'h00000005, 32'h00001005, '0);
    serve_memory();
    // An add on the previous destination alone hits on every operand.
    send_beat(KIND_ADD, 32'h00001005, 32'h00001005, 32'h00001005, '0);
    serve_memory();
    // A flush writes back every dirty line from the lowest index up.
    send_beat(KIND_FLUSH, '0, '0, '0, '0);
    serve_memory();

    for (int n = 0; n < 850; n++) begin
      // A long stretch with no idling on either channel.
      quiet_stretch = (n >= 200 && n < 350);
      // The response side holds off long enough that requests back up.
      if (n == 450) hold_off = 300;
      // The request side waits until every owed response has arrived.
      if (n == 600) begin
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (sb.owed.size() != 0) @(posedge clk);
      end
      random_step();
    end
    serve_memory();
    req_ch.valid <= 1'b0;

    while (sb.owed.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (sb.mismatches == 0 && sb.owed.size() == 0) begin
      $display("writeback_cache_add_controller_tb: PASS");
    end else begin
      $display("writeback_cache_add_controller_tb: FAIL");
    end
    $finish;
  end

endmodule

### files.f
rtl/wcac_pkg.sv
rtl/wcac_if.sv
rtl/wcac_ram.sv
rtl/writeback_cache_add_controller.sv
test/writeback_cache_add_controller_tb.sv
